// File: rtl/segtree_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the segment tree range sum block.
// Field widths and item mode codes; no dependencies.
package segtree_pkg;

   // Widths of the fixed payload fields.
   localparam int SUM_W   = 42;
   localparam int COUNT_W = 11;
   localparam int POS_W   = 10;

   // Item modes.
   localparam logic MODE_SET   = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

endpackage

// File: rtl/segment_tree_range_sum.sv
`timescale 1ns / 1ps
// Set item: one leaf read and write, then one tree memory read and one write per level on the leaf path.
// Query item: one tree memory read per covered node.
// One item at a time; a finished word may wait at the output while the next is taken.
// Reset and each element_count write start a clearing pass of the tree and leaf memories
// during which req_stall is high.
// Reset is synchronous and active high; it clears control state only.
// Segment tree range sum with point update: sequencer, tree and leaf memories.
// Depends on segtree_pkg for field widths and mode codes.
module segment_tree_range_sum #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int VALUE_WIDTH  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_mode,
   input  logic [segtree_pkg::POS_W-1:0]       req_element_index,
   input  logic signed [VALUE_WIDTH-1:0]       req_value,
   input  logic [segtree_pkg::POS_W-1:0]       req_range_low,
   input  logic [segtree_pkg::POS_W-1:0]       req_range_high,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [segtree_pkg::SUM_W-1:0] rsp_range_sum,
   output logic                                rsp_index_error,
   input  logic                                csr_write_enable,
   input  logic [segtree_pkg::COUNT_W-1:0]     csr_write_data
);

   localparam int IDX_W  = $clog2(MAX_ELEMENTS);
   localparam int NODE_W = IDX_W + 1;
   localparam int TREE_N = 2 ** NODE_W;
   localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
   localparam int CMP_W  = (CNT_W > segtree_pkg::COUNT_W) ? CNT_W : segtree_pkg::COUNT_W;
   localparam int STK_N  = IDX_W + 1;
   localparam int SP_W   = $clog2(STK_N + 1);
   localparam int STK_A  = $clog2(STK_N);
   localparam int SUM_W  = segtree_pkg::SUM_W;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DIFF,
      S_PREAD,
      S_PWRITE,
      S_QUERY,
      S_FLUSH,
      S_OUT
   } state_type;

   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic [IDX_W-1:0]  s;
      logic [IDX_W-1:0]  e;
   } stack_entry_type;

   // Control and payload registers.
   state_type                  state_ff, state_in;
   logic [NODE_W-1:0]          clr_ff, clr_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [SP_W-1:0]            sp_ff, sp_in;
   logic                       pend_ff, pend_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]           rsp_sum_ff, rsp_sum_in;
   logic                       rsp_err_ff, rsp_err_in;
   logic                       err_ff, err_in;
   logic [segtree_pkg::POS_W-1:0] idx_ff, idx_in;
   logic [segtree_pkg::POS_W-1:0] lo_ff, lo_in;
   logic [segtree_pkg::POS_W-1:0] hi_ff, hi_in;
   logic [VALUE_WIDTH-1:0]     value_ff, value_in;
   logic [SUM_W-1:0]           diff_ff, diff_in;
   logic [SUM_W-1:0]           acc_ff, acc_in;
   logic [NODE_W-1:0]          node_ff, node_in;
   logic [IDX_W-1:0]           s_ff, s_in;
   logic [IDX_W-1:0]           e_ff, e_in;
   stack_entry_type            stk_ff [STK_N];

   // Memory ports.
   logic [SUM_W-1:0]           tree_mem [TREE_N];
   logic [VALUE_WIDTH-1:0]     leaf_mem [MAX_ELEMENTS];
   logic                       tree_re, tree_we, leaf_re, leaf_we;
   logic [NODE_W-1:0]          tree_ra, tree_wa;
   logic [SUM_W-1:0]           tree_wd, tree_q;
   logic [IDX_W-1:0]           leaf_ra, leaf_wa;
   logic [VALUE_WIDTH-1:0]     leaf_wd, leaf_q;

   // Stack push port.
   logic                       stk_we;
   stack_entry_type            stk_wd;
   stack_entry_type            stk_top;

   // Datapath helpers.
   logic [IDX_W:0]             se_sum;
   logic [IDX_W-1:0]           mid;
   logic [IDX_W-1:0]           mid_p1;
   logic [NODE_W-1:0]          child_l, child_r;
   logic [IDX_W-1:0]           cnt_m1;
   logic [CMP_W-1:0]           csr_ext;
   logic [CMP_W-1:0]           lo_ext, hi_ext, s_ext, e_ext;
   logic                       covered, disjoint;
   logic [SUM_W-1:0]           acc_add;
   logic [SP_W-1:0]            sp_m1;

   assign se_sum  = (IDX_W + 1)'(s_ff) + (IDX_W + 1)'(e_ff);
   assign mid     = se_sum[IDX_W:1];
   assign mid_p1  = mid + IDX_W'(1);
   assign child_l = {node_ff[NODE_W-2:0], 1'b1};
   assign child_r = child_l + NODE_W'(1);
   assign cnt_m1  = IDX_W'(cnt_ff - CNT_W'(1));
   assign csr_ext = CMP_W'(csr_write_data);
   assign lo_ext  = CMP_W'(lo_ff);
   assign hi_ext  = CMP_W'(hi_ff);
   assign s_ext   = CMP_W'(s_ff);
   assign e_ext   = CMP_W'(e_ff);
   assign covered  = (lo_ext <= s_ext) && (hi_ext >= e_ext);
   assign disjoint = (hi_ext < s_ext) || (lo_ext > e_ext);
   assign acc_add  = pend_ff ? (acc_ff + tree_q) : acc_ff;
   assign sp_m1    = sp_ff - SP_W'(1);
   assign stk_top  = stk_ff[sp_m1[STK_A-1:0]];

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_range_sum   = rsp_sum_ff;
   assign rsp_index_error = rsp_err_ff;

   // Sequencer: next state and memory port control.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cnt_in       = cnt_ff;
      sp_in        = sp_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_sum_in   = rsp_sum_ff;
      rsp_err_in   = rsp_err_ff;
      err_in       = err_ff;
      idx_in       = idx_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      value_in     = value_ff;
      diff_in      = diff_ff;
      acc_in       = acc_ff;
      node_in      = node_ff;
      s_in         = s_ff;
      e_in         = e_ff;
      tree_re      = 1'b0;
      tree_ra      = node_ff;
      tree_we      = 1'b0;
      tree_wa      = node_ff;
      tree_wd      = tree_q + diff_ff;
      leaf_re      = 1'b0;
      leaf_ra      = IDX_W'(req_element_index);
      leaf_we      = 1'b0;
      leaf_wa      = IDX_W'(idx_ff);
      leaf_wd      = value_ff;
      stk_we       = 1'b0;
      stk_wd       = '{node: child_r, s: mid_p1, e: e_ff};

      case (state_ff)
         // Zero both stores, one entry a cycle.
         S_CLEAR: begin
            tree_we = 1'b1;
            tree_wa = clr_ff;
            tree_wd = '0;
            leaf_wa = clr_ff[IDX_W-1:0];
            leaf_wd = '0;
            leaf_we = (clr_ff < NODE_W'(MAX_ELEMENTS));
            clr_in  = clr_ff + NODE_W'(1);
            if (clr_ff == NODE_W'(TREE_N - 1)) begin
               state_in = S_IDLE;
            end
         end

         // Take a new word and start either the update or the query walk.
         S_IDLE: begin
            if (req_valid) begin
               idx_in   = req_element_index;
               lo_in    = req_range_low;
               hi_in    = req_range_high;
               value_in = req_value;
               err_in   = 1'b0;
               acc_in   = '0;
               pend_in  = 1'b0;
               sp_in    = '0;
               node_in  = '0;
               s_in     = '0;
               e_in     = cnt_m1;
               if (req_mode == segtree_pkg::MODE_SET) begin
                  if (CMP_W'(req_element_index) >= CMP_W'(cnt_ff)) begin
                     err_in   = 1'b1;
                     state_in = S_OUT;
                  end else begin
                     leaf_re  = 1'b1;
                     state_in = S_DIFF;
                  end
               end else if (req_range_low > req_range_high) begin
                  state_in = S_OUT;
               end else begin
                  state_in = S_QUERY;
               end
            end
         end

         // Old leaf is in; form the difference and store the new leaf.
         S_DIFF: begin
            diff_in  = SUM_W'(signed'(value_ff)) - SUM_W'(signed'(leaf_q));
            leaf_we  = 1'b1;
            state_in = S_PREAD;
         end

         // Update walk, read half: fetch the node on the path.
         S_PREAD: begin
            tree_re  = 1'b1;
            state_in = S_PWRITE;
         end

         // Update walk, write half: add the difference and step toward the leaf.
         S_PWRITE: begin
            tree_we = 1'b1;
            if (s_ff == e_ff) begin
               state_in = S_OUT;
            end else begin
               state_in = S_PREAD;
               if (CMP_W'(idx_ff) <= CMP_W'(mid)) begin
                  node_in = child_l;
                  e_in    = mid;
               end else begin
                  node_in = child_r;
                  s_in    = mid_p1;
               end
            end
         end

         // Query walk: one node a cycle, right halves wait on the stack.
         S_QUERY: begin
            acc_in  = acc_add;
            pend_in = 1'b0;
            if (covered || disjoint) begin
               if (covered) begin
                  tree_re = 1'b1;
                  pend_in = 1'b1;
               end
               if (sp_ff != '0) begin
                  node_in = stk_top.node;
                  s_in    = stk_top.s;
                  e_in    = stk_top.e;
                  sp_in   = sp_m1;
               end else begin
                  state_in = S_FLUSH;
               end
            end else begin
               stk_we  = 1'b1;
               sp_in   = sp_ff + SP_W'(1);
               node_in = child_l;
               e_in    = mid;
            end
         end

         // Pick up the last node sum still in flight.
         S_FLUSH: begin
            acc_in   = acc_add;
            pend_in  = 1'b0;
            state_in = S_OUT;
         end

         // Hand the result to the output register once it is free.
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = acc_ff;
               rsp_err_in   = err_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_CLEAR;
            clr_in   = '0;
         end
      endcase

      // A count write clamps the count and restarts the clearing pass.
      if (csr_write_enable) begin
         if (csr_ext == '0) begin
            cnt_in = CNT_W'(1);
         end else if (csr_ext > CMP_W'(MAX_ELEMENTS)) begin
            cnt_in = CNT_W'(MAX_ELEMENTS);
         end else begin
            cnt_in = CNT_W'(csr_ext);
         end
         state_in = S_CLEAR;
         clr_in   = '0;
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= CNT_W'(MAX_ELEMENTS);
         sp_ff        <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         sp_ff        <= sp_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_sum_ff <= rsp_sum_in;
      rsp_err_ff <= rsp_err_in;
      err_ff     <= err_in;
      idx_ff     <= idx_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      value_ff   <= value_in;
      diff_ff    <= diff_in;
      acc_ff     <= acc_in;
      node_ff    <= node_in;
      s_ff       <= s_in;
      e_ff       <= e_in;
      if (stk_we) begin
         stk_ff[sp_ff[STK_A-1:0]] <= stk_wd;
      end
   end

   // Tree sum memory: one write and one registered read port.
   always_ff @(posedge clock) begin
      if (tree_we) begin
         tree_mem[tree_wa] <= tree_wd;
      end
      if (tree_re) begin
         tree_q <= tree_mem[tree_ra];
      end
   end

   // Leaf copy memory: one write and one registered read port.
   always_ff @(posedge clock) begin
      if (leaf_we) begin
         leaf_mem[leaf_wa] <= leaf_wd;
      end
      if (leaf_re) begin
         leaf_q <= leaf_mem[leaf_ra];
      end
   end

`ifndef SYNTHESIS
   // An accepted word always starts a walk or goes straight to the output.
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !csr_write_enable) |=> (state_ff != S_IDLE))
      else $error("accepted word did not start work");

   // No word is taken while the stores are being cleared.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> req_stall)
      else $error("word accepted during clearing pass");

   // The query stack never runs past its depth.
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STK_N))
      else $error("query stack overflow");

   // A node read in flight is only folded in during the query walk.
   a_pend_in_query: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == S_QUERY || state_ff == S_FLUSH))
      else $error("stray pending node read");

   // A rejected set carries a zero sum.
   a_err_zero_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_index_error) |-> (rsp_range_sum == '0))
      else $error("rejected set with nonzero sum");
`endif

endmodule

// File: test/tb_segment_tree_range_sum.sv
`timescale 1ns / 1ps
// Self-checking testbench for segment_tree_range_sum: point sets and range sum queries.
// Depends on segtree_pkg and the segment_tree_range_sum RTL; needs no other files.
module tb_segment_tree_range_sum;

   localparam int MAX_ELEMENTS  = 1024;
   localparam int VALUE_WIDTH   = 32;
   localparam int SETTLE_CYCLES = 64;
   localparam int REPORT_LIMIT  = 100;
   localparam int SUM_W         = segtree_pkg::SUM_W;
   localparam int POS_W         = segtree_pkg::POS_W;
   localparam int COUNT_W       = segtree_pkg::COUNT_W;

   typedef struct packed {
      logic signed [SUM_W-1:0] range_sum;
      logic                    index_error;
   } result_word_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_mode = segtree_pkg::MODE_SET;
   logic [POS_W-1:0]              req_element_index = '0;
   logic signed [VALUE_WIDTH-1:0] req_value = '0;
   logic [POS_W-1:0]              req_range_low = '0;
   logic [POS_W-1:0]              req_range_high = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [SUM_W-1:0]       rsp_range_sum;
   logic                          rsp_index_error;
   logic                          csr_write_enable = 1'b0;
   logic [COUNT_W-1:0]            csr_write_data = '0;

   // Mirror of the element array and the element_count register.
   int              element_values [MAX_ELEMENTS];
   int              active_count = MAX_ELEMENTS;
   result_word_type pending_words [$];
   int              error_count = 0;
   int              send_idle_pct = 0;
   int              rsp_stall_pct = 0;

   segment_tree_range_sum #(
      .MAX_ELEMENTS(MAX_ELEMENTS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_element_index(req_element_index),
      .req_value        (req_value),
      .req_range_low    (req_range_low),
      .req_range_high   (req_range_high),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_range_sum    (rsp_range_sum),
      .rsp_index_error  (rsp_index_error),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // A generous bound on the whole run.
   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

   // Random back-pressure on the result channel.
   always @(posedge clock) begin
      rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(99) < rsp_stall_pct);
   end

   // Compare each accepted result word with the oldest expected one.
   always @(posedge clock) begin
      result_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("%0t: no word expected, got sum %0d error %0b",
                        $time, rsp_range_sum, rsp_index_error);
         end else begin
            want = pending_words.pop_front();
            if (rsp_range_sum !== want.range_sum || rsp_index_error !== want.index_error) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("%0t: expected sum %0d error %0b, got sum %0d error %0b",
                           $time, want.range_sum, want.index_error,
                           rsp_range_sum, rsp_index_error);
            end
         end
      end
   end

   // A count of zero acts as one; anything above the array size acts as the array size.
   function automatic int effective_count(logic [COUNT_W-1:0] raw);
      int c;
      c = int'(raw);
      if (c == 0)
         c = 1;
      if (c > MAX_ELEMENTS)
         c = MAX_ELEMENTS;
      return c;
   endfunction

   // Sum over the inclusive span; indices at or past the count add nothing, and an
   // empty span (low above high) leaves the loop without a pass.
   function automatic logic signed [SUM_W-1:0] span_sum(int lo, int hi);
      longint acc;
      int     top;
      acc = 0;
      top = (hi < active_count) ? hi : active_count - 1;
      for (int i = lo; i <= top; i++)
         acc += element_values[i];
      return SUM_W'(acc);
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Send one word, with random idle cycles ahead of it, and record its expected result.
   task automatic send_word(input logic mode, input logic [POS_W-1:0] index,
                            input logic [31:0] value, input logic [POS_W-1:0] low,
                            input logic [POS_W-1:0] high);
      result_word_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_mode          <= mode;
      req_element_index <= index;
      req_value         <= value;
      req_range_low     <= low;
      req_range_high    <= high;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      want = '0;
      if (mode == segtree_pkg::MODE_SET) begin
         if (int'(index) >= active_count)
            want.index_error = 1'b1;
         else
            element_values[index] = value;
      end else begin
         want.range_sum = span_sum(int'(low), int'(high));
      end
      pending_words.push_back(want);
   endtask

   task automatic set_element(input int index, input logic [31:0] value);
      send_word(segtree_pkg::MODE_SET, POS_W'(index), value, POS_W'($urandom),
                POS_W'($urandom));
   endtask

   task automatic query_span(input int low, input int high);
      send_word(segtree_pkg::MODE_QUERY, POS_W'($urandom), $urandom, POS_W'(low),
                POS_W'(high));
   endtask

   // Hold off the sender until every expected word is back, then wait a little more.
   task automatic wait_drained(input int tail);
      req_valid <= 1'b0;
      while (pending_words.size() != 0)
         @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   // A count write clears both stores inside the block, so the mirror is cleared too.
   task automatic write_element_count(input int count_value);
      wait_drained(SETTLE_CYCLES);
      csr_write_enable <= 1'b1;
      csr_write_data   <= COUNT_W'(count_value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      active_count = effective_count(COUNT_W'(count_value));
      foreach (element_values[i])
         element_values[i] = 0;
   endtask

   // Extreme values at both ends of the full array, overwrites and empty spans.
   task automatic test_point_updates();
      set_element(0, 32'h7FFF_FFFF);
      set_element(MAX_ELEMENTS - 1, 32'h8000_0000);
      set_element(512, 32'hFFFF_FFFF);
      set_element(0, 32'h0000_0000);
      set_element(0, 32'h7FFF_FFFF);
      query_span(0, MAX_ELEMENTS - 1);
      query_span(0, 0);
      query_span(MAX_ELEMENTS - 1, MAX_ELEMENTS - 1);
      query_span(511, 512);
      query_span(5, 3);
      query_span(MAX_ELEMENTS - 1, 0);
   endtask

   // Small counts, a zero count, an oversized count and the clearing on each write.
   task automatic test_count_limits();
      write_element_count(5);
      set_element(4, 123456);
      set_element(5, 32'h1234_5678);
      set_element(MAX_ELEMENTS - 1, 32'h7FFF_FFFF);
      query_span(0, MAX_ELEMENTS - 1);
      query_span(3, MAX_ELEMENTS - 1);
      query_span(5, MAX_ELEMENTS - 1);
      write_element_count(0);
      set_element(0, -7);
      set_element(1, 99);
      query_span(0, MAX_ELEMENTS - 1);
      write_element_count(11'h7FF);
      query_span(0, MAX_ELEMENTS - 1);
      set_element(MAX_ELEMENTS - 1, 32'h8000_0000);
      query_span(1000, MAX_ELEMENTS - 1);
   endtask

   // Mixed sets and queries under one count and one idling pattern.
   task automatic test_random_traffic(input int count_value,
                                      input int num_words, input int idle_pct,
                                      input int stall_pct);
      int lo;
      int hi;
      int index;
      write_element_count(count_value);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int n = 0; n < num_words; n++) begin
         if ($urandom_range(1) == 0) begin
            // Mostly in-range sets, some at the count boundary or anywhere.
            case ($urandom_range(9))
               0: index = $urandom_range(MAX_ELEMENTS - 1);
               1: index = (active_count < MAX_ELEMENTS) ? active_count : active_count - 1;
               default: index = $urandom_range(active_count - 1);
            endcase
            set_element(index, pick_value());
         end else begin
            case ($urandom_range(9))
               0: begin
                  lo = 0;
                  hi = MAX_ELEMENTS - 1;
               end
               1, 2: begin
                  lo = $urandom_range(MAX_ELEMENTS - 1);
                  hi = $urandom_range(MAX_ELEMENTS - 1);
               end
               default: begin
                  lo = $urandom_range(active_count - 1);
                  hi = $urandom_range(active_count - 1, lo);
               end
            endcase
            query_span(lo, hi);
         end
         // Now and then let the pipeline empty out completely.
         if ($urandom_range(49) == 0)
            wait_drained(1);
      end
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   initial begin
      foreach (element_values[i])
         element_values[i] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_point_updates();
      test_count_limits();
      test_random_traffic(MAX_ELEMENTS, 350, 0, 0);
      test_random_traffic(37, 250, 53, 0);
      test_random_traffic(1000, 250, 0, 53);
      test_random_traffic(2, 150, 10, 10);
      test_random_traffic(3, 125, 0, 0);

      wait_drained(SETTLE_CYCLES);
      if (error_count == 0 && pending_words.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
